// ----- sv/flxd_pkg.sv -----
package flxd_pkg;

  localparam int INDEX_BITS = 17;
  localparam int IDX_OUT_W  = 17;
  localparam int RQ_DEPTH   = 4;

  localparam logic [7:0] RST_INVALID_BELOW = 8'h48;
  localparam logic [7:0] RST_MEDIUM_FROM   = 8'h78;
  localparam logic [7:0] RST_LONG_FROM     = 8'hA8;
  localparam logic [7:0] RST_INVALID_FROM  = 8'hE0;

  typedef enum logic [1:0] {
    CFG_INVALID_BELOW = 2'd0,
    CFG_MEDIUM_FROM   = 2'd1,
    CFG_LONG_FROM     = 2'd2,
    CFG_INVALID_FROM  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_SHORT   = 2'd0,
    CLS_MEDIUM  = 2'd1,
    CLS_LONG    = 2'd2,
    CLS_INVALID = 2'd3
  } flux_class_e;

  typedef struct packed {
    logic [7:0] invalid_below;
    logic [7:0] medium_from;
    logic [7:0] long_from;
    logic [7:0] invalid_from;
  } thr_t;

  typedef struct packed {
    logic [7:0] store;
    logic [2:0] fill;
    logic       prev;
  } bits_t;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic [IDX_OUT_W-1:0] byte_index;
    logic                 partial;
    logic                 session_end;
  } result_t;

endpackage

// ----- sv/flux_interval_bit_decoder_top.sv -----
// An accepted interval is registered and decoded, and its results are written into
// the result queue, from whose head they are offered.
// Throughput: one interval per cycle; an interval that completes a byte and ends a
// session with a partial byte yields two results, which leave one at a time.
// Intake pauses once the four-entry result queue could not take two more results.
// Reset sets thresholds to their defaults and clears the bit store and byte index.
module flux_interval_bit_decoder_top #(
  parameter int IndexBits  = flxd_pkg::INDEX_BITS,
  parameter int QueueDepth = flxd_pkg::RQ_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  interval_i,
  input  logic        end_of_write_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic [16:0] byte_index_o,
  output logic        partial_o,
  output logic        session_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int CntW = $clog2(QueueDepth+1);

  flxd_pkg::thr_t       thr_q;
  logic                 item_vld_q;
  logic [7:0]           item_int_q;
  logic                 item_eow_q;
  flxd_pkg::bits_t      bits_q, bits_d;
  logic [IndexBits-1:0] ctr_q, ctr_d;
  logic [1:0]           dec_n;
  logic [1:0]           push_n;
  flxd_pkg::result_t    res0, res1, head;
  logic [CntW-1:0]      q_count;
  logic                 pop;
  logic [CntW:0]        fill_est;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.invalid_below <= flxd_pkg::RST_INVALID_BELOW;
      thr_q.medium_from   <= flxd_pkg::RST_MEDIUM_FROM;
      thr_q.long_from     <= flxd_pkg::RST_LONG_FROM;
      thr_q.invalid_from  <= flxd_pkg::RST_INVALID_FROM;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (flxd_pkg::cfg_reg_e'(cfg_index_i))
        flxd_pkg::CFG_INVALID_BELOW: thr_q.invalid_below <= cfg_data_i;
        flxd_pkg::CFG_MEDIUM_FROM:   thr_q.medium_from   <= cfg_data_i;
        flxd_pkg::CFG_LONG_FROM:     thr_q.long_from     <= cfg_data_i;
        flxd_pkg::CFG_INVALID_FROM:  thr_q.invalid_from  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  flxd_decode #(
    .IndexBits(IndexBits)
  ) u_decode (
    .interval_i (item_int_q),
    .last_i     (item_eow_q),
    .thr_i      (thr_q),
    .bits_i     (bits_q),
    .ctr_i      (ctr_q),
    .bits_o     (bits_d),
    .ctr_o      (ctr_d),
    .count_o    (dec_n),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  assign push_n = item_vld_q ? dec_n : 2'd0;

  // hold off a new request unless the queue can take two more results
  assign fill_est   = {1'b0, q_count} + (CntW+1)'(push_n);
  assign in_ready_o = fill_est <= (CntW+1)'(QueueDepth - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      bits_q     <= '0;
      ctr_q      <= '0;
    end else begin
      item_vld_q <= in_valid_i && in_ready_o;
      if (item_vld_q) begin
        bits_q <= bits_d;
        ctr_q  <= ctr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_int_q <= interval_i;
      item_eow_q <= end_of_write_i;
    end
  end

  assign pop = out_valid_o && out_ready_i;

  flxd_rq #(
    .Depth(QueueDepth)
  ) u_rq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .pop_i    (pop),
    .head_o   (head),
    .count_o  (q_count)
  );

  assign out_valid_o   = q_count != '0;
  assign data_byte_o   = head.data_byte;
  assign byte_index_o  = head.byte_index;
  assign partial_o     = head.partial;
  assign session_end_o = head.session_end;

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QueueDepth))
    else $error("result queue overflow");

  a_item_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> item_vld_q)
    else $error("accepted request not registered");

  a_partial_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && partial_o |-> session_end_o)
    else $error("partial byte without session end");

  a_session_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && item_eow_q |=> bits_q.fill == 3'd0 && ctr_q == '0)
    else $error("state not cleared after session end");

endmodule

// ----- sv/flxd_decode.sv -----
module flxd_decode #(
  parameter int IndexBits = flxd_pkg::INDEX_BITS
) (
  input  logic [7:0]           interval_i,
  input  logic                 last_i,
  input  flxd_pkg::thr_t       thr_i,
  input  flxd_pkg::bits_t      bits_i,
  input  logic [IndexBits-1:0] ctr_i,
  output flxd_pkg::bits_t      bits_o,
  output logic [IndexBits-1:0] ctr_o,
  output logic [1:0]           count_o,
  output flxd_pkg::result_t    res0_o,
  output flxd_pkg::result_t    res1_o
);

  localparam int OutW = flxd_pkg::IDX_OUT_W;

  flxd_pkg::flux_class_e cls;
  logic                  two;
  logic [1:0]            val;
  logic                  prev_n;
  logic [9:0]            wide;
  logic [3:0]            fill_sum;
  logic                  full;
  logic [7:0]            store_rem;
  logic [2:0]            fill_rem;
  logic [IndexBits-1:0]  ctr_inc;
  logic                  has_part;
  flxd_pkg::result_t     full_res;
  flxd_pkg::result_t     part_res;

  always_comb begin
    if (interval_i < thr_i.invalid_below) begin
      cls = flxd_pkg::CLS_INVALID;
    end else if (interval_i < thr_i.medium_from) begin
      cls = flxd_pkg::CLS_SHORT;
    end else if (interval_i < thr_i.long_from) begin
      cls = flxd_pkg::CLS_MEDIUM;
    end else if (interval_i < thr_i.invalid_from) begin
      cls = flxd_pkg::CLS_LONG;
    end else begin
      cls = flxd_pkg::CLS_INVALID;
    end
  end

  always_comb begin
    two    = 1'b0;
    val    = 2'b00;
    prev_n = 1'b0;
    if (bits_i.prev) begin
      unique case (cls)
        flxd_pkg::CLS_SHORT: begin
          val    = 2'b01;
          prev_n = 1'b1;
        end
        flxd_pkg::CLS_MEDIUM: begin
          two = 1'b1;
        end
        flxd_pkg::CLS_LONG: begin
          two    = 1'b1;
          val    = 2'b10;
          prev_n = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (cls)
        flxd_pkg::CLS_MEDIUM: begin
          val    = 2'b01;
          prev_n = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign wide      = {2'b00, bits_i.store} | ({8'h00, val} << bits_i.fill);
  assign fill_sum  = {1'b0, bits_i.fill} + (two ? 4'd2 : 4'd1);
  assign full      = fill_sum[3];
  assign store_rem = full ? {6'd0, wide[9:8]} : wide[7:0];
  assign fill_rem  = fill_sum[2:0];
  assign ctr_inc   = ctr_i + IndexBits'(full);
  assign has_part  = last_i && (fill_rem != 3'd0);

  assign full_res.data_byte   = wide[7:0];
  assign full_res.byte_index  = OutW'(ctr_i);
  assign full_res.partial     = 1'b0;
  assign full_res.session_end = last_i && (fill_rem == 3'd0);

  assign part_res.data_byte   = store_rem;
  assign part_res.byte_index  = OutW'(ctr_inc);
  assign part_res.partial     = 1'b1;
  assign part_res.session_end = 1'b1;

  assign res0_o  = full ? full_res : part_res;
  assign res1_o  = part_res;
  assign count_o = {1'b0, full} + {1'b0, has_part};

  // drop all state after the last interval of a session
  always_comb begin
    if (last_i) begin
      bits_o = '0;
      ctr_o  = '0;
    end else begin
      bits_o.store = store_rem;
      bits_o.fill  = fill_rem;
      bits_o.prev  = prev_n;
      ctr_o        = ctr_inc;
    end
  end

endmodule

// ----- sv/flxd_rq.sv -----
module flxd_rq #(
  parameter int Depth = flxd_pkg::RQ_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  flxd_pkg::result_t          res0_i,
  input  flxd_pkg::result_t          res1_i,
  input  logic                       pop_i,
  output flxd_pkg::result_t          head_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth+1);

  flxd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth-1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_d = wr_q;
    if (push_n_i == 2'd1) begin
      wr_d = inc(wr_q);
    end else if (push_n_i == 2'd2) begin
      wr_d = inc(inc(wr_q));
    end
    rd_d  = pop_i ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_n_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[inc(wr_q)] <= res1_i;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ----- tb/flux_interval_bit_decoder_top_tb.sv -----
`timescale 1ns / 1ps

module flux_interval_bit_decoder_top_tb;
  import flxd_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_REQS = 175;

  typedef struct {
    logic [7:0] interval;
    logic       last;
  } flux_req_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  interval_i = '0;
  logic        end_of_write_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  data_byte_o;
  logic [16:0] byte_index_o;
  logic        partial_o;
  logic        session_end_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  flux_req_t pending_flux[$];
  result_t   expected_bytes[$];

  thr_t                  thr;
  logic [8:0]            acc_bits;
  int unsigned           acc_fill;
  logic                  last_bit;
  logic [INDEX_BITS-1:0] byte_no;

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;

  flux_interval_bit_decoder_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .interval_i     (interval_i),
    .end_of_write_i (end_of_write_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .partial_o      (partial_o),
    .session_end_o  (session_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk = ~clk;

  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(20, 60);
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic flux_class_e classify_interval(logic [7:0] iv);
    if (iv < thr.invalid_below) return CLS_INVALID;
    if (iv < thr.medium_from) return CLS_SHORT;
    if (iv < thr.long_from) return CLS_MEDIUM;
    if (iv < thr.invalid_from) return CLS_LONG;
    return CLS_INVALID;
  endfunction

  task automatic push_bit(logic b);
    acc_bits[acc_fill] = b;
    acc_fill++;
  endtask

  task automatic clear_session();
    acc_bits = '0;
    acc_fill = 0;
    last_bit = 1'b0;
    byte_no  = '0;
  endtask

  task automatic decode_interval(logic [7:0] iv, logic last);
    flux_class_e c;
    result_t     r;
    c = classify_interval(iv);
    if (c == CLS_SHORT) begin
      push_bit(last_bit);
    end else if (c == CLS_MEDIUM && !last_bit) begin
      push_bit(1'b1);
      last_bit = 1'b1;
    end else if (c == CLS_MEDIUM) begin
      push_bit(1'b0);
      push_bit(1'b0);
      last_bit = 1'b0;
    end else if (c == CLS_LONG && last_bit) begin
      push_bit(1'b0);
      push_bit(1'b1);
    end else begin
      push_bit(1'b0);
      last_bit = 1'b0;
    end
    if (acc_fill >= 8) begin
      r.data_byte   = acc_bits[7:0];
      r.byte_index  = byte_no;
      r.partial     = 1'b0;
      r.session_end = last && acc_fill == 8;
      expected_bytes.push_back(r);
      acc_bits = acc_bits >> 8;
      acc_fill -= 8;
      byte_no++;
    end
    if (last) begin
      if (acc_fill != 0) begin
        r.data_byte   = acc_bits[7:0];
        r.byte_index  = byte_no;
        r.partial     = 1'b1;
        r.session_end = 1'b1;
        expected_bytes.push_back(r);
      end
      clear_session();
    end
  endtask

  task automatic queue_req(logic [7:0] iv, logic last);
    flux_req_t q;
    q.interval = iv;
    q.last     = last;
    pending_flux.push_back(q);
  endtask

  function automatic logic [7:0] pick_interval();
    logic [7:0] t[4];
    logic [7:0] a;
    logic [7:0] b;
    int         v;
    t[0] = thr.invalid_below;
    t[1] = thr.medium_from;
    t[2] = thr.long_from;
    t[3] = thr.invalid_from;
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: begin
        v = int'(t[$urandom_range(0, 3)]) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
      end
      default: begin
        a = t[$urandom_range(0, 3)];
        b = t[$urandom_range(0, 3)];
        if (a > b) return 8'($urandom_range(b, a));
        return 8'($urandom_range(a, b));
      end
    endcase
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      CFG_INVALID_BELOW: thr.invalid_below = val;
      CFG_MEDIUM_FROM:   thr.medium_from = val;
      CFG_LONG_FROM:     thr.long_from = val;
      CFG_INVALID_FROM:  thr.invalid_from = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(thr_t t);
    write_reg(CFG_INVALID_BELOW, t.invalid_below);
    write_reg(CFG_MEDIUM_FROM, t.medium_from);
    write_reg(CFG_LONG_FROM, t.long_from);
    write_reg(CFG_INVALID_FROM, t.invalid_from);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_flux.size() != 0 || in_valid_i || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic      hold;
    flux_req_t q;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_interval(interval_i, end_of_write_i);
      end
      hold = in_valid_i && !in_ready_o;
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_flux.size() != 0) begin
          q = pending_flux.pop_front();
          interval_i     <= q.interval;
          end_of_write_i <= q.last;
          hold = 1'b1;
          in_gap = idle_len(in_calm);
        end
      end
      in_valid_i <= hold;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected byte %h idx %0d partial %b end %b",
                     data_byte_o, byte_index_o, partial_o, session_end_o);
          end
        end else begin
          e = expected_bytes.pop_front();
          if (data_byte_o !== e.data_byte || byte_index_o !== e.byte_index ||
              partial_o !== e.partial || session_end_o !== e.session_end) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp byte %h idx %0d partial %b end %b, got %h %0d %b %b",
                       e.data_byte, e.byte_index, e.partial, e.session_end,
                       data_byte_o, byte_index_o, partial_o, session_end_o);
            end
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_stall = idle_len(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL flux_interval_bit_decoder_top");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    thr_t       plan[$];
    thr_t       t;
    logic [7:0] dir_iv[$];
    logic       dir_last[$];
    thr.invalid_below = RST_INVALID_BELOW;
    thr.medium_from   = RST_MEDIUM_FROM;
    thr.long_from     = RST_LONG_FROM;
    thr.invalid_from  = RST_INVALID_FROM;
    clear_session();

    plan.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
    plan.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    plan.push_back('{8'd0, 8'd1, 8'd254, 8'd255});
    plan.push_back('{8'd200, 8'd100, 8'd150, 8'd50});
    plan.push_back('{8'd30, 8'd30, 8'd90, 8'd90});
    plan.push_back('{8'd10, 8'd200, 8'd100, 8'd250});
    repeat (3) begin
      t.invalid_below = 8'($urandom_range(0, 80));
      t.medium_from   = t.invalid_below + 8'($urandom_range(0, 60));
      t.long_from     = t.medium_from + 8'($urandom_range(0, 60));
      t.invalid_from  = t.long_from + 8'($urandom_range(0, 55));
      plan.push_back(t);
    end
    plan.push_back('{RST_INVALID_BELOW, RST_MEDIUM_FROM, RST_LONG_FROM, RST_INVALID_FROM});

    // every class after either previous bit, then a session of exactly eight bits,
    // a one-bit session, and a session ending on nine bits
    dir_iv = '{8'd0, 8'd71, 8'd72, 8'd119, 8'd120, 8'd100, 8'd150, 8'd168, 8'd120,
               8'd200, 8'd223, 8'd224, 8'd255,
               8'd80, 8'd80, 8'd80, 8'd80, 8'd80, 8'd80, 8'd80, 8'd80,
               8'd90, 8'd130, 8'd190, 8'd190, 8'd190, 8'd130};
    dir_last = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                 1'b0, 1'b0, 1'b0, 1'b1,
                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (int p = 0; p <= plan.size(); p++) begin
      if (p > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        set_thresholds(plan[p-1]);
      end else begin
        foreach (dir_iv[i]) queue_req(dir_iv[i], dir_last[i]);
      end
      repeat (PHASE_REQS) queue_req(pick_interval(), $urandom_range(0, 23) == 0);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("PASS flux_interval_bit_decoder_top");
    end else begin
      $display("FAIL flux_interval_bit_decoder_top");
    end
    $finish;
  end

endmodule
